// ===== rtl/grbf_pkg.sv =====
// Shared constants, tables and control types for the Gaussian RBF color similarity block.
package grbf_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    localparam int SLOT_W   = 6;
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int WEIGHT_W = 32;
    localparam int RES_W    = 40;
    localparam int SIU_W    = 7;
    localparam int SIGMA_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SIU_W-1:0]   SIU_RESET   = 7'd54;
    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'd10880;

    // Input item kinds carried on the command field.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_Q        = 1'd1;

    localparam int R2_W  = 18;
    localparam int X_W   = SIGMA_W + R2_W;
    localparam int EXP_W = 17;
    localparam logic [X_W-1:0] EXP_LIMIT = X_W'(17 * 256);

    typedef logic [EXP_W-1:0] t_exp_int_tab [32];
    typedef logic [EXP_W-1:0] t_exp_frac_tab [256];

    // round(65536*exp(-n)); entries past sixteen are never used.
    localparam t_exp_int_tab EXP_INT_TAB = '{
        17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
        17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0,
        17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
        17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
    };

    // Unsigned quotient by shift and subtract; the divisor stays far below 2^63.
    function automatic longint unsigned f_udiv64(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Builds round(65536*exp(-f/256)) from an alternating Taylor series in Q52.
    // Evaluated only at elaboration.
    function automatic t_exp_frac_tab f_exp_frac_tab();
        t_exp_frac_tab   tab;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned term;
        longint unsigned den;
        for (int f = 0; f < 256; f++) begin
            pos  = 64'd1 << 52;
            neg  = 64'd0;
            term = 64'd1 << 52;
            for (int k = 1; k < 40; k++) begin
                if (term != 64'd0) begin
                    den  = 64'(256 * k);
                    term = f_udiv64(term * 64'(f), den);
                    if ((k & 1) == 1) begin
                        neg = neg + term;
                    end else begin
                        pos = pos + term;
                    end
                end
            end
            tab[f] = EXP_W'(((pos - neg) + (64'd1 << 35)) >> 36);
        end
        return tab;
    endfunction

    localparam t_exp_frac_tab EXP_FRAC_TAB = f_exp_frac_tab();

    // Controller to datapath commands.
    typedef struct packed {
        logic              wr_en;
        logic              ld_pixel;
        logic              issue;
        logic [ADDR_W-1:0] addr;
        logic              load_out;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic busy;
    } t_sts;

endpackage

// ===== rtl/grbf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module grbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/grbf_dp.sv =====
// Datapath: sample stores, distance and exponential pipeline, saturating accumulator.
module grbf_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  grbf_pkg::t_cmd                       i_cmd,
    output grbf_pkg::t_sts                       o_sts,
    input  logic [grbf_pkg::SLOT_W-1:0]          i_slot,
    input  logic [grbf_pkg::CHAN_W-1:0]          i_chan_blue,
    input  logic [grbf_pkg::CHAN_W-1:0]          i_chan_green,
    input  logic [grbf_pkg::CHAN_W-1:0]          i_chan_red,
    input  logic signed [grbf_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [grbf_pkg::SIGMA_W-1:0]         i_sigma_q,
    output logic [grbf_pkg::RES_W-1:0]           o_similarity
);

    localparam int CW   = grbf_pkg::CHAN_W;
    localparam int WW   = grbf_pkg::WEIGHT_W;
    localparam int PW   = WW + grbf_pkg::EXP_W + 1;
    localparam int TW   = PW - 16;
    localparam int RW   = grbf_pkg::RES_W;

    logic [grbf_pkg::COLOR_W-1:0] q_color;
    logic [WW-1:0]                q_weight;

    grbf_ram #(.WIDTH(grbf_pkg::COLOR_W), .DEPTH(grbf_pkg::MAX_SAMPLES)) u_color_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (grbf_pkg::ADDR_W'(i_slot)),
        .i_wr_data ({i_chan_red, i_chan_green, i_chan_blue}),
        .i_rd_addr (i_cmd.addr),
        .o_rd_data (q_color)
    );

    grbf_ram #(.WIDTH(WW), .DEPTH(grbf_pkg::MAX_SAMPLES)) u_weight_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (grbf_pkg::ADDR_W'(i_slot)),
        .i_wr_data (i_weight),
        .i_rd_addr (i_cmd.addr),
        .o_rd_data (q_weight)
    );

    // Pixel under evaluation.
    logic [CW-1:0] r_px_b, r_px_g, r_px_r;

    // Stage valids.
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;

    logic [grbf_pkg::R2_W-1:0]  r_r2;
    logic [grbf_pkg::X_W-1:0]   r_x;
    logic                       r_zero;
    logic [grbf_pkg::EXP_W-1:0] r_e, r_f, r_g;
    logic signed [WW-1:0]       r_w1, r_w2, r_w3, r_w4;
    logic signed [PW-1:0]       r_prod;
    logic signed [RW-1:0]       r_acc, n_acc;
    logic [RW-1:0]              r_res;

    logic [CW-1:0]                db, dg, dr;
    logic [grbf_pkg::R2_W-1:0]    r2;
    logic [2*grbf_pkg::EXP_W-1:0] ef;
    logic [2*grbf_pkg::EXP_W-1:0] ef_rnd;
    logic signed [PW-1:0]         prod_rnd;
    logic signed [TW-1:0]         term;
    logic signed [RW:0]           sum;

    always_comb begin
        db = (r_px_b > q_color[CW-1:0])    ? r_px_b - q_color[CW-1:0]
                                           : q_color[CW-1:0] - r_px_b;
        dg = (r_px_g > q_color[2*CW-1:CW]) ? r_px_g - q_color[2*CW-1:CW]
                                           : q_color[2*CW-1:CW] - r_px_g;
        dr = (r_px_r > q_color[3*CW-1:2*CW]) ? r_px_r - q_color[3*CW-1:2*CW]
                                             : q_color[3*CW-1:2*CW] - r_px_r;
        r2 = grbf_pkg::R2_W'(db) * grbf_pkg::R2_W'(db)
           + grbf_pkg::R2_W'(dg) * grbf_pkg::R2_W'(dg)
           + grbf_pkg::R2_W'(dr) * grbf_pkg::R2_W'(dr);

        ef     = r_e * r_f;
        ef_rnd = ef + (2*grbf_pkg::EXP_W)'(32768);

        // Round half up from Q.32 to Q.16: add one half, then floor.
        prod_rnd = r_prod + PW'(32768);
        term     = prod_rnd[PW-1:16];
        sum      = {r_acc[RW-1], r_acc} + (RW+1)'(term);
        if (sum[RW] != sum[RW-1]) begin
            n_acc = sum[RW] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
        end else begin
            n_acc = sum[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_pixel) begin
            r_px_b <= i_chan_blue;
            r_px_g <= i_chan_green;
            r_px_r <= i_chan_red;
        end

        r_r2 <= r2;
        r_w1 <= q_weight;

        r_x  <= i_sigma_q * r_r2;
        r_w2 <= r_w1;

        r_zero <= (r_x >= grbf_pkg::EXP_LIMIT);
        r_e    <= grbf_pkg::EXP_INT_TAB[r_x[12:8]];
        r_f    <= grbf_pkg::EXP_FRAC_TAB[r_x[7:0]];
        r_w3   <= r_w2;

        r_g  <= r_zero ? '0 : ef_rnd[16 +: grbf_pkg::EXP_W];
        r_w4 <= r_w3;

        r_prod <= r_w4 * $signed({1'b0, r_g});

        if (i_cmd.ld_pixel) begin
            r_acc <= '0;
        end else if (r_v5) begin
            r_acc <= n_acc;
        end

        if (i_cmd.load_out) begin
            r_res <= r_acc;
        end
    end

    assign o_sts.busy   = r_v0 | r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign o_similarity = r_res;

    // A new pixel is never latched while samples of the previous one are in flight.
    a_pixel_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_pixel |-> !o_sts.busy)
        else $error("pixel latched while pipeline busy");

    // The result is captured only after the last term has been accumulated.
    a_out_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_v5 && !r_v4)
        else $error("result captured before pipeline drained");

endmodule

// ===== rtl/grbf_ctrl.sv =====
// Controller: item acceptance, sample address sequencing and result handoff.
module grbf_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic                              i_command,
    input  logic [grbf_pkg::SLOT_W-1:0]       i_slot,
    input  logic [grbf_pkg::SIU_W-1:0]        i_samples_in_use,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output grbf_pkg::t_cmd                    o_cmd,
    input  grbf_pkg::t_sts                    i_sts
);

    localparam int CNT_W = grbf_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_n, n_n;
    logic             r_out_valid, n_out_valid;

    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] n_use;
    logic [CNT_W-1:0] cnt_inc;

    always_comb begin
        accept   = i_s_tvalid && (r_state == ST_IDLE);
        out_free = !r_out_valid || i_m_tready;
        cnt_inc  = CNT_W'(r_cnt + 1'b1);
        n_use    = (32'(i_samples_in_use) > grbf_pkg::MAX_SAMPLES)
                 ? CNT_W'(grbf_pkg::MAX_SAMPLES) : CNT_W'(i_samples_in_use);

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_out_valid = r_out_valid && !i_m_tready;

        o_cmd          = '0;
        o_cmd.addr     = r_cnt[grbf_pkg::ADDR_W-1:0];
        o_cmd.wr_en    = accept && (i_command == grbf_pkg::CMD_LOAD)
                      && (32'(i_slot) < grbf_pkg::MAX_SAMPLES);
        o_cmd.ld_pixel = accept && (i_command == grbf_pkg::CMD_EVAL);

        case (r_state)
            ST_IDLE: begin
                if (o_cmd.ld_pixel) begin
                    n_cnt   = '0;
                    n_n     = n_use;
                    n_state = (n_use == '0) ? ST_WAIT : ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                n_cnt       = cnt_inc;
                if (cnt_inc == r_n) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!i_sts.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    // Only slots inside the summed range are ever read.
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_cnt < r_n))
        else $error("sample address beyond samples in use");

    // The result is produced only once the datapath has drained.
    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> !i_sts.busy)
        else $error("result stage entered with pipeline busy");

    // A waiting word is never overwritten by the next result.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before it was taken");

endmodule

// ===== rtl/gaussian_rbf_color_similarity.sv =====
// Top level of the Gaussian RBF color similarity block: ports, configuration and wiring.
//
// A load word stores one sample color and its signed Q16.16 weight into a slot. An
// evaluate word walks slots 0 to N-1, N being samples_in_use capped at 64, through one
// shared pipeline (absolute differences and squares, sigma multiply, two exponential
// table lookups and their product, weight multiply, saturating 40-bit accumulate) that
// takes one stored sample per cycle from a single read port on each of the two sample
// memories. An evaluation occupies the block through the issue of its N samples, the
// pipeline fill and drain and the result handoff, after which the next word is accepted.
// The result sits in an output register, so a new word is accepted while the previous
// result still waits to be taken. Reading a slot that was never loaded gives an undefined
// contribution.
module gaussian_rbf_color_similarity (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input words.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] slot, [13:6] chan_blue, [21:14] chan_green, [29:22] chan_red,
    // [61:30] weight, [63:62] zero
    input  logic [63:0]                         s_axis_tdata,
    // [0] command
    input  logic [0:0]                          s_axis_tuser,
    // Result words.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [39:0] similarity
    output logic [grbf_pkg::RES_W-1:0]          m_axis_tdata,
    // Configuration writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [grbf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [grbf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [grbf_pkg::SIU_W-1:0]   r_samples_in_use;
    logic [grbf_pkg::SIGMA_W-1:0] r_sigma_q;

    grbf_pkg::t_cmd cmd;
    grbf_pkg::t_sts sts;

    logic [grbf_pkg::SLOT_W-1:0]          slot;
    logic [grbf_pkg::CHAN_W-1:0]          chan_blue, chan_green, chan_red;
    logic signed [grbf_pkg::WEIGHT_W-1:0] weight;

    assign slot       = s_axis_tdata[5:0];
    assign chan_blue  = s_axis_tdata[13:6];
    assign chan_green = s_axis_tdata[21:14];
    assign chan_red   = s_axis_tdata[29:22];
    assign weight     = s_axis_tdata[61:30];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_in_use <= grbf_pkg::SIU_RESET;
            r_sigma_q        <= grbf_pkg::SIGMA_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                grbf_pkg::CFG_SAMPLES_IN_USE: begin
                    r_samples_in_use <= i_cfg_data[grbf_pkg::SIU_W-1:0];
                end
                grbf_pkg::CFG_SIGMA_Q: begin
                    r_sigma_q <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    grbf_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_axis_tvalid),
        .o_s_tready       (s_axis_tready),
        .i_command        (s_axis_tuser[0]),
        .i_slot           (slot),
        .i_samples_in_use (r_samples_in_use),
        .o_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .o_cmd            (cmd),
        .i_sts            (sts)
    );

    grbf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_slot       (slot),
        .i_chan_blue  (chan_blue),
        .i_chan_green (chan_green),
        .i_chan_red   (chan_red),
        .i_weight     (weight),
        .i_sigma_q    (r_sigma_q),
        .o_similarity (m_axis_tdata)
    );

endmodule

// ===== dv/gaussian_rbf_color_similarity_tb.sv =====
// Self-checking testbench for the Gaussian RBF color similarity block.
module gaussian_rbf_color_similarity_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT    = 64;
    localparam int GAUSS_CUTOFF  = 17 * 256;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 20;
    localparam int FINAL_CYCLES  = 100;
    localparam longint SIM_MAX   = 64'sd549755813887;
    localparam longint SIM_MIN   = -64'sd549755813888;

    typedef struct {
        logic               cmd;
        logic [5:0]         slot;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic signed [31:0] weight;
    } t_pixel_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [63:0]                         s_axis_tdata = '0;
    logic [0:0]                          s_axis_tuser = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [grbf_pkg::RES_W-1:0]          m_axis_tdata;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [grbf_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [grbf_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;

    gaussian_rbf_color_similarity i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor state, updated as words and register writes are accepted.
    logic [6:0]         cur_samples_in_use = 7'd54;
    logic [15:0]        cur_sigma_q = 16'd10880;
    logic [23:0]        sample_color [SLOT_COUNT];
    logic signed [31:0] sample_weight [SLOT_COUNT];
    longint unsigned    frac_exp_q16 [256];
    logic [39:0]        expected_similarity [$];

    // Generation-side view, used to keep evaluations on loaded slots.
    logic [23:0]        planned_color [SLOT_COUNT];
    bit                 planned_loaded [SLOT_COUNT];
    int                 planned_samples = 54;

    t_pixel_word        pending_words [$];
    t_pixel_word        cur_word;
    bit                 in_fire = 1'b0;
    bit                 idle_on = 1'b1;
    bit                 hold_request = 1'b0;
    bit                 hold_seen = 1'b0;
    int                 tx_gap = 0;
    int                 rx_gap = 0;
    int                 hold_left = 0;
    int                 n_fail = 0;
    int                 n_checked = 0;
    int                 n_loads = 0;
    int                 n_evals = 0;
    int                 n_cfg = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // round(65536*exp(-n)) for the integer part of the exponent.
    function automatic longint int_exp_q16(input int n);
        case (n)
            0:       return 65536;
            1:       return 24109;
            2:       return 8869;
            3:       return 3263;
            4:       return 1200;
            5:       return 442;
            6:       return 162;
            7:       return 60;
            8:       return 22;
            9:       return 8;
            10:      return 3;
            11:      return 1;
            default: return 0;
        endcase
    endfunction

    // Fractional exponent table from an alternating series in Q52, rounded to Q16.
    function automatic void build_frac_exp();
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned term;
        for (int f = 0; f < 256; f++) begin
            pos  = 64'd1 << 52;
            neg  = 64'd0;
            term = 64'd1 << 52;
            for (int k = 1; k < 40; k++) begin
                if (term != 64'd0) begin
                    term = (term * longint'(f)) / (64'd256 * longint'(k));
                    if (k % 2 == 1) neg += term;
                    else pos += term;
                end
            end
            frac_exp_q16[f] = ((pos - neg) + (64'd1 << 35)) >> 36;
        end
    endfunction

    function automatic longint chan_dist(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function automatic logic [39:0] predict_similarity(input t_pixel_word w);
        longint          acc;
        longint          term;
        longint          gauss;
        longint          db;
        longint          dg;
        longint          dr;
        longint unsigned x;
        int              n;
        n   = (cur_samples_in_use > SLOT_COUNT) ? SLOT_COUNT : int'(cur_samples_in_use);
        acc = 0;
        for (int i = 0; i < n; i++) begin
            db = chan_dist(w.blue, sample_color[i][7:0]);
            dg = chan_dist(w.green, sample_color[i][15:8]);
            dr = chan_dist(w.red, sample_color[i][23:16]);
            x  = longint'(cur_sigma_q) * (db * db + dg * dg + dr * dr);
            if (x >= GAUSS_CUTOFF) begin
                gauss = 0;
            end else begin
                gauss = (int_exp_q16(int'(x >> 8)) * longint'(frac_exp_q16[x[7:0]]) + 32768)
                        >>> 16;
            end
            // Arithmetic shift gives the floor, so adding one half rounds half up.
            term = (longint'(sample_weight[i]) * gauss + 32768) >>> 16;
            acc  = acc + term;
            if (acc > SIM_MAX) acc = SIM_MAX;
            if (acc < SIM_MIN) acc = SIM_MIN;
        end
        return acc[39:0];
    endfunction

    // Monitor: register writes, accepted words and result words, all sampled at the rising edge.
    always @(posedge i_clk) begin
        in_fire = s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == grbf_pkg::CFG_SAMPLES_IN_USE) begin
                    cur_samples_in_use = i_cfg_data[6:0];
                end else if (i_cfg_index == grbf_pkg::CFG_SIGMA_Q) begin
                    cur_sigma_q = i_cfg_data;
                end
            end
            if (in_fire) begin
                if (cur_word.cmd == grbf_pkg::CMD_LOAD) begin
                    sample_color[cur_word.slot]  = {cur_word.red, cur_word.green, cur_word.blue};
                    sample_weight[cur_word.slot] = cur_word.weight;
                end else begin
                    expected_similarity.insert(expected_similarity.size(),
                                               predict_similarity(cur_word));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_similarity.size() == 0) begin
                    $error("unexpected result word: similarity %0d", $signed(m_axis_tdata));
                    n_fail++;
                end else begin
                    if (m_axis_tdata !== expected_similarity[0]) begin
                        $error("similarity mismatch: expected %0d actual %0d",
                               $signed(expected_similarity[0]), $signed(m_axis_tdata));
                        n_fail++;
                    end
                    void'(expected_similarity.pop_front());
                    n_checked++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Input driver: presents queued words and holds each until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (tx_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                tx_gap--;
            end else if (pending_words.size() > 0) begin
                cur_word = pending_words.pop_front();
                s_axis_tdata  <= {2'b00, cur_word.weight, cur_word.red, cur_word.green,
                                  cur_word.blue, cur_word.slot};
                s_axis_tuser  <= cur_word.cmd;
                s_axis_tvalid <= 1'b1;
                tx_gap = idle_on ? pick_gap() : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure plus one long hold when requested.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            hold_seen    = 1'b1;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap--;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(3, 0) == 0) rx_gap = pick_gap();
        end
    end

    task automatic cfg_write(input logic [grbf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [grbf_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic set_config(input int samples, input int sigma);
        cfg_write(grbf_pkg::CFG_SAMPLES_IN_USE, {9'($urandom_range(511, 0)), 7'(samples)});
        cfg_write(grbf_pkg::CFG_SIGMA_Q, 16'(sigma));
        planned_samples = samples % 128;
    endtask

    // Sender pause: nothing pending, nothing expected, then let loads settle.
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_similarity.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_load(input int slot, input logic [23:0] color, input logic [31:0] w);
        t_pixel_word pw;
        pw.cmd    = grbf_pkg::CMD_LOAD;
        pw.slot   = 6'(slot);
        pw.blue   = color[7:0];
        pw.green  = color[15:8];
        pw.red    = color[23:16];
        pw.weight = w;
        planned_color[slot]  = color;
        planned_loaded[slot] = 1'b1;
        pending_words.insert(pending_words.size(), pw);
        n_loads++;
    endtask

    task automatic queue_eval(input logic [23:0] color);
        t_pixel_word pw;
        // Fields the block ignores on evaluation still toggle.
        pw.cmd    = grbf_pkg::CMD_EVAL;
        pw.slot   = 6'($urandom);
        pw.blue   = color[7:0];
        pw.green  = color[15:8];
        pw.red    = color[23:16];
        pw.weight = $urandom;
        pending_words.insert(pending_words.size(), pw);
        n_evals++;
    endtask

    function automatic bit eval_allowed();
        int n;
        n = (planned_samples > SLOT_COUNT) ? SLOT_COUNT : planned_samples;
        for (int i = 0; i < n; i++)
            if (!planned_loaded[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [23:0] near_color(input logic [23:0] c, input int spread);
        logic [23:0] res;
        int          v;
        for (int ch = 0; ch < 3; ch++) begin
            v = int'(c[ch*8 +: 8]) + $urandom_range(2 * spread, 0) - spread;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            res[ch*8 +: 8] = 8'(v);
        end
        return res;
    endfunction

    function automatic logic [31:0] random_weight();
        case ($urandom_range(9, 0))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'($signed($urandom_range(262143, 0)) - 131072);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random_load();
        logic [23:0] color;
        if ($urandom_range(1, 0) == 0) color = 24'($urandom);
        else color = near_color(planned_color[$urandom_range(SLOT_COUNT - 1, 0)], 8);
        queue_load($urandom_range(SLOT_COUNT - 1, 0), color, random_weight());
    endtask

    task automatic queue_random_eval();
        int          r;
        int          n;
        logic [23:0] base;
        n    = (planned_samples > SLOT_COUNT) ? SLOT_COUNT : planned_samples;
        base = planned_color[(n > 0) ? $urandom_range(n - 1, 0) : $urandom_range(63, 0)];
        r    = $urandom_range(9, 0);
        if (r < 6) queue_eval(near_color(base, 3));
        else if (r < 7) queue_eval(base);
        else queue_eval(24'($urandom));
    endtask

    task automatic run_phase(input int samples, input int sigma, input int count,
                             input int load_pct, input bit quiet, input bit long_hold);
        wait_drained();
        set_config(samples, sigma);
        idle_on = !quiet;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99, 0) < load_pct || !eval_allowed()) queue_random_load();
            else queue_random_eval();
        end
        if (long_hold) hold_request = 1'b1;
    endtask

    initial begin
        int order [SLOT_COUNT];
        int j;
        int t;
        build_frac_exp();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            sample_color[i]   = '0;
            sample_weight[i]  = '0;
            planned_color[i]  = '0;
            planned_loaded[i] = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no samples summed, then extreme colors and weights at the sigma extremes.
        set_config(0, 10880);
        queue_eval(24'h000000);
        queue_eval(24'hFFFFFF);
        queue_load(0, 24'h000000, 32'h7FFF_FFFF);
        queue_load(1, 24'hFFFFFF, 32'h8000_0000);
        queue_load(63, 24'h3CA55A, 32'hFFFF_FFFF);
        queue_load(2, 24'hFE0180, 32'h0001_0000);
        wait_drained();
        set_config(2, 0);
        queue_eval(24'h000000);
        queue_eval(24'hFFFFFF);
        wait_drained();
        // Small sigma: exact match, a fractional exponent, an integer step and the cutoff.
        set_config(2, 1);
        queue_eval(24'h000000);
        queue_eval(24'h000001);
        queue_eval(24'h001000);
        queue_eval(24'hFFFFFE);
        queue_eval(24'h004200);
        wait_drained();
        set_config(2, 65535);
        queue_eval(24'h000000);
        queue_eval(24'h010000);

        // Fill every slot in random order before wider evaluations.
        wait_drained();
        set_config(2, 10880);
        for (int i = 0; i < SLOT_COUNT; i++) order[i] = i;
        for (int i = SLOT_COUNT - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            queue_load(order[i], 24'($urandom), random_weight());
            if (i % 4 == 3) queue_random_eval();
        end

        run_phase(64, 10880, 40, 20, 1'b0, 1'b1);
        run_phase(127, 16, 40, 25, 1'b0, 1'b0);
        run_phase(1, 0, 30, 30, 1'b1, 1'b0);
        run_phase(33, 256, 40, 25, 1'b0, 1'b0);
        run_phase(64, 65535, 30, 20, 1'b0, 1'b0);
        run_phase(0, 5, 20, 30, 1'b0, 1'b0);
        run_phase(100, 2, 40, 25, 1'b0, 1'b0);
        run_phase(20, $urandom_range(128, 1), 40, 25, 1'b1, 1'b0);
        run_phase(54, $urandom_range(64, 1), 40, 25, 1'b0, 1'b0);

        wait_drained();
        repeat (FINAL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d load words, %0d evaluations and %0d register writes.",
                 n_loads, n_evals, n_cfg);
        $display("Checked %0d result words; long output hold applied: %0d.",
                 n_checked, hold_seen);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/grbf_pkg.sv
rtl/grbf_ram.sv
rtl/grbf_dp.sv
rtl/grbf_ctrl.sv
rtl/gaussian_rbf_color_similarity.sv
dv/gaussian_rbf_color_similarity_tb.sv
